[rtl/core/lgps_pkg.sv]
package lgps_pkg;

  localparam int DEF_MAX_STOPS  = 8;
  localparam int DEF_IMAGE_SIZE = 64;

  localparam int COORD_W    = 24;
  localparam int POS_W      = 17;
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 12;
  localparam int PIX_W      = 6;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int ENTRY_W    = POS_W + COLOR_W;

  // shared divider sizes: den is dx*dx + dy*dy, num is |dot| with 16 fraction bits
  localparam int DIV_DEN_W  = 49;
  localparam int FRAC_W     = 16;
  localparam int DIV_NUM_W  = DIV_DEN_W + FRAC_W;
  localparam int DIV_STEP_W = 7;
  localparam int LERP_W     = 25;

  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_SEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd7;

  localparam logic [MODE_W-1:0] SPREAD_PAD     = 2'd0;
  localparam logic [MODE_W-1:0] SPREAD_REPEAT  = 2'd1;
  localparam logic [MODE_W-1:0] SPREAD_REFLECT = 2'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SHADE = 1'b1;

  localparam logic [COORD_W-1:0] RST_END_X       = 24'd16384;
  localparam logic [COORD_W-1:0] RST_PATH_SIZE   = 24'd16384;
  localparam logic [COUNT_W-1:0] RST_STOP_COUNT  = 4'd2;

  typedef struct packed {
    logic             req_type;
    logic [2:0]       stop_index;
    logic [POS_W-1:0] stop_offset;
    logic [7:0]       stop_red;
    logic [7:0]       stop_green;
    logic [7:0]       stop_blue;
    logic [7:0]       stop_alpha;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } request_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [ADDR_W-1:0]  pixel_address;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_GO,
    S_SC_WAIT,
    S_DIFF,
    S_MUL,
    S_G_GO,
    S_G_WAIT,
    S_RD0,
    S_CHK0,
    S_CHKN,
    S_SCAN,
    S_L_GO,
    S_L_WAIT,
    S_DONE
  } state_t;

endpackage

[rtl/core/lgps_ram.sv]
module lgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lgps_div.sv]
module lgps_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [lgps_pkg::DIV_NUM_W-1:0]  num,
  input  logic [lgps_pkg::DIV_DEN_W-1:0]  den,
  input  logic [lgps_pkg::DIV_STEP_W-1:0] steps,
  output logic                            done,
  output logic [lgps_pkg::DIV_NUM_W-1:0]  quo,
  output logic                            rem_nz
);
  import lgps_pkg::*;

  logic                  running;
  logic [DIV_STEP_W-1:0] cnt;
  logic [DIV_NUM_W-1:0]  nreg;
  logic [DIV_DEN_W-1:0]  rreg;
  logic [DIV_DEN_W-1:0]  dreg;
  logic [DIV_DEN_W:0]    trial;
  logic [DIV_DEN_W:0]    diff;
  logic                  fits;
  logic [DIV_DEN_W-1:0]  r_next;

  // restoring step, numerator arrives left aligned
  always_comb begin
    trial  = {rreg, nreg[DIV_NUM_W-1]};
    fits   = trial >= {1'b0, dreg};
    diff   = trial - {1'b0, dreg};
    r_next = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_STEP_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      nreg <= num;
      rreg <= '0;
      dreg <= den;
      cnt  <= steps;
    end else if (running) begin
      nreg <= {nreg[DIV_NUM_W-2:0], fits};
      rreg <= r_next;
      cnt  <= cnt - DIV_STEP_W'(1);
    end
  end

  assign quo    = nreg;
  assign rem_nz = rreg != '0;

  a_go_idle: assert property (@(posedge clk) disable iff (rst) go |-> !running)
    else $error("divider restarted while running");
  a_done_stops: assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still running");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (running && cnt == DIV_STEP_W'(1) && !go) |=> done)
    else $error("divider missed its done pulse");

endmodule

[rtl/core/linear_gradient_pixel_shader.sv]
// Linear gradient shader. A load item (req_type 0) writes one color stop in the
// cycle it is taken and leaves busy low. A shade item keeps busy high while one
// shared restoring divider, one bit per cycle, runs in turn, each run with a
// launch state and a wait state that takes its quotient: four endpoint scalings,
// the gradient parameter, and four channel interpolations, plus a dot product, a
// stop search that reads one stop at a time, and the result state. The
// interpolations are skipped when the first or last stop is taken as it is, and
// the gradient division is skipped on a zero-length axis; the next item can be
// taken in the cycle after done.
// The result appears on result for the one cycle that done is high; the receiver
// cannot stall it, so it must be taken then. Configuration writes are always
// ready; the user must keep them to idle periods; the block does not enforce this.
module linear_gradient_pixel_shader #(
  parameter int MAX_STOPS  = lgps_pkg::DEF_MAX_STOPS,
  parameter int IMAGE_SIZE = lgps_pkg::DEF_IMAGE_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  lgps_pkg::request_t              request,
  output logic                            done,
  output lgps_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lgps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lgps_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int SW = 32 + $clog2(IMAGE_SIZE);
  localparam logic signed [SW:0] SCALE_K = (SW+1)'(IMAGE_SIZE * 256);
  localparam logic signed [SW:0] SAT_HI = (SW+1)'(24'sh7FFFFF);
  localparam logic signed [SW:0] SAT_LO = {{(SW+1-COORD_W){1'b1}}, 24'h800000};
  localparam int PW = 2 * (COORD_W + 1);
  localparam int ACC_W = PW + 1;

  state_t state, state_next;

  // configuration
  logic [MODE_W-1:0]  spread_sel;
  logic [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic [COORD_W-1:0] size_x, size_y;
  logic [COUNT_W-1:0] stop_count;

  // datapath registers
  logic [PIX_W-1:0]          px, py;
  logic [ADDR_W-1:0]         addr;
  logic [1:0]                sc;
  logic signed [COORD_W-1:0] coord [4];
  logic signed [COORD_W:0]   dx, dy, ux, uy;
  logic [2:0]                mcnt;
  logic signed [PW-1:0]      prod;
  logic signed [ACC_W-1:0]   den_acc, num_acc;
  logic                      neg;
  logic [POS_W-1:0]          g;
  logic [AW-1:0]             k;
  logic [ENTRY_W-1:0]        prev;
  logic [COLOR_W-1:0]        c0, c1, color;
  logic [POS_W-1:0]          t, span;
  logic [1:0]                ch;

  // divider and ram hookup
  logic                  div_go, div_done, div_rnz;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;
  logic [DIV_DEN_W-1:0]  div_den;
  logic [DIV_STEP_W-1:0] div_steps;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, rdata;
  logic [POS_W-1:0]      rd_pos, prev_pos;
  logic [COLOR_W-1:0]    rd_col;

  // combinational helpers
  logic                  accept;
  logic signed [COORD_W-1:0] sc_raw;
  logic [COORD_W-1:0]    sc_size;
  logic signed [SW:0]    sc_prod;
  logic [SW:0]           sc_abs, sc_pos, sc_val;
  logic [ACC_W-1:0]      num_abs;
  logic [DIV_NUM_W+1:0]  g_pos, g_val;
  logic [POS_W-1:0]      g_frac, g_new;
  logic [AW-1:0]         n_last;
  logic signed [COORD_W:0] op_a, op_b;
  logic [7:0]            ch_a, ch_b;
  logic [LERP_W-1:0]     lerp_num;
  logic [31:0]           addr_full;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign rd_pos   = rdata[ENTRY_W-1 -: POS_W];
  assign rd_col   = rdata[COLOR_W-1:0];
  assign prev_pos = prev[ENTRY_W-1 -: POS_W];

  assign addr_full = 32'(request.pixel_y) * 32'(IMAGE_SIZE) + 32'(request.pixel_x);

  always_comb begin
    case (sc)
      2'd0:    sc_raw = start_x;
      2'd1:    sc_raw = start_y;
      2'd2:    sc_raw = end_x;
      default: sc_raw = end_y;
    endcase
    sc_size = sc[0] ? size_y : size_x;
    if (sc_size == '0) begin
      sc_size = COORD_W'(1);
    end
    sc_prod = $signed({{(SW+1-COORD_W){sc_raw[COORD_W-1]}}, sc_raw}) * SCALE_K;
    sc_abs  = sc_prod[SW] ? (SW+1)'(-sc_prod) : (SW+1)'(sc_prod);
    // floor of a negative quotient rounds the magnitude up
    sc_pos  = {1'b0, div_quo[SW-1:0]} + (SW+1)'(div_rnz);
    sc_val  = neg ? (SW+1)'(-sc_pos) : {1'b0, div_quo[SW-1:0]};
  end

  always_comb begin
    num_abs = num_acc[ACC_W-1] ? ACC_W'(-num_acc) : ACC_W'(num_acc);
    g_pos   = {2'b00, div_quo} + (DIV_NUM_W+2)'(div_rnz);
    g_val   = neg ? (DIV_NUM_W+2)'(-g_pos) : {2'b00, div_quo};
    g_frac  = {1'b0, g_val[FRAC_W-1:0]};
    case (spread_sel)
      SPREAD_REPEAT:  g_new = g_frac;
      SPREAD_REFLECT: g_new = g_val[FRAC_W] ? POS_W'(17'h10000) - g_frac : g_frac;
      default: begin
        if (g_val[DIV_NUM_W+1]) begin
          g_new = '0;
        end else if (|g_val[DIV_NUM_W:FRAC_W]) begin
          g_new = POS_W'(17'h10000);
        end else begin
          g_new = g_frac;
        end
      end
    endcase
  end

  always_comb begin
    if (stop_count == '0) begin
      n_last = '0;
    end else if (int'(stop_count) > MAX_STOPS) begin
      n_last = AW'(MAX_STOPS - 1);
    end else begin
      n_last = AW'(stop_count - COUNT_W'(1));
    end
  end

  always_comb begin
    case (mcnt)
      3'd0: begin op_a = dx; op_b = dx; end
      3'd1: begin op_a = dy; op_b = dy; end
      3'd2: begin op_a = dx; op_b = ux; end
      default: begin op_a = dy; op_b = uy; end
    endcase
    ch_a     = c0[8*ch +: 8];
    ch_b     = c1[8*ch +: 8];
    lerp_num = LERP_W'(ch_a) * LERP_W'(span - t) + LERP_W'(ch_b) * LERP_W'(t);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept && request.req_type == REQ_SHADE) state_next = S_SC_GO;
      S_SC_GO:   state_next = S_SC_WAIT;
      S_SC_WAIT: if (div_done) state_next = (sc == 2'd3) ? S_DIFF : S_SC_GO;
      S_DIFF:    state_next = S_MUL;
      S_MUL:     if (mcnt == 3'd4) state_next = S_G_GO;
      S_G_GO:    state_next = (den_acc == '0) ? S_RD0 : S_G_WAIT;
      S_G_WAIT:  if (div_done) state_next = S_RD0;
      S_RD0:     state_next = S_CHK0;
      S_CHK0:    state_next = (g <= rd_pos) ? S_DONE : S_CHKN;
      S_CHKN:    state_next = (g >= rd_pos) ? S_DONE : S_SCAN;
      S_SCAN:    if (!(k < n_last && g >= rd_pos)) state_next = S_L_GO;
      S_L_GO:    state_next = S_L_WAIT;
      S_L_WAIT:  if (div_done) state_next = (ch == 2'd3) ? S_DONE : S_L_GO;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and unit controls
  always_comb begin
    busy      = state != S_IDLE;
    done      = state == S_DONE;
    div_go    = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    ram_raddr = '0;
    unique case (state)
      S_SC_GO: begin
        div_go    = 1'b1;
        div_num   = {sc_abs[SW-1:0], {(DIV_NUM_W-SW){1'b0}}};
        div_den   = DIV_DEN_W'(sc_size);
        div_steps = DIV_STEP_W'(SW);
      end
      S_G_GO: begin
        div_go    = den_acc != '0;
        div_num   = {num_abs[DIV_DEN_W-1:0], {FRAC_W{1'b0}}};
        div_den   = den_acc[DIV_DEN_W-1:0];
        div_steps = DIV_STEP_W'(DIV_NUM_W);
      end
      S_L_GO: begin
        div_go    = 1'b1;
        div_num   = {lerp_num, {(DIV_NUM_W-LERP_W){1'b0}}};
        div_den   = DIV_DEN_W'(span);
        div_steps = DIV_STEP_W'(LERP_W);
      end
      S_CHK0:  ram_raddr = n_last;
      S_CHKN:  ram_raddr = AW'(1);
      S_SCAN:  ram_raddr = k + AW'(1);
      default: ram_raddr = '0;
    endcase
  end

  assign ram_we    = accept && request.req_type == REQ_LOAD
                     && int'(request.stop_index) < MAX_STOPS;
  assign ram_waddr = AW'(request.stop_index);
  assign ram_wdata = {request.stop_offset, request.stop_alpha, request.stop_blue,
                      request.stop_green, request.stop_red};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      spread_sel  <= SPREAD_PAD;
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= RST_END_X;
      end_y       <= '0;
      size_x      <= RST_PATH_SIZE;
      size_y      <= RST_PATH_SIZE;
      stop_count  <= RST_STOP_COUNT;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SPREAD_SEL:  spread_sel  <= cfg_data[MODE_W-1:0];
          REG_START_X:     start_x     <= cfg_data;
          REG_START_Y:     start_y     <= cfg_data;
          REG_END_X:       end_x       <= cfg_data;
          REG_END_Y:       end_y       <= cfg_data;
          REG_SIZE_X:      size_x      <= cfg_data;
          REG_SIZE_Y:      size_y      <= cfg_data;
          REG_STOP_COUNT:  stop_count  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px   <= request.pixel_x;
        py   <= request.pixel_y;
        addr <= addr_full[ADDR_W-1:0];
        sc   <= '0;
      end
      S_SC_GO: neg <= sc_prod[SW];
      S_SC_WAIT: begin
        if (div_done) begin
          if ($signed(sc_val) > SAT_HI) begin
            coord[sc] <= 24'sh7FFFFF;
          end else if ($signed(sc_val) < SAT_LO) begin
            coord[sc] <= 24'sh800000;
          end else begin
            coord[sc] <= sc_val[COORD_W-1:0];
          end
          sc <= sc + 2'd1;
        end
      end
      S_DIFF: begin
        dx      <= (COORD_W+1)'(coord[2]) - (COORD_W+1)'(coord[0]);
        dy      <= (COORD_W+1)'(coord[3]) - (COORD_W+1)'(coord[1]);
        ux      <= $signed({11'b0, px, 8'b0}) - (COORD_W+1)'(coord[0]);
        uy      <= $signed({11'b0, py, 8'b0}) - (COORD_W+1)'(coord[1]);
        den_acc <= '0;
        num_acc <= '0;
        mcnt    <= '0;
      end
      S_MUL: begin
        // product of the previous cycle lands in its accumulator
        prod <= op_a * op_b;
        mcnt <= mcnt + 3'd1;
        if (mcnt == 3'd1 || mcnt == 3'd2) begin
          den_acc <= den_acc + ACC_W'(prod);
        end else if (mcnt == 3'd3 || mcnt == 3'd4) begin
          num_acc <= num_acc + ACC_W'(prod);
        end
      end
      S_G_GO: begin
        neg <= num_acc[ACC_W-1];
        if (den_acc == '0) begin
          g <= '0;
        end
      end
      S_G_WAIT: if (div_done) g <= g_new;
      S_CHK0: begin
        prev  <= rdata;
        color <= rd_col;
      end
      S_CHKN: begin
        color <= rd_col;
        k     <= AW'(1);
      end
      S_SCAN: begin
        if (k < n_last && g >= rd_pos) begin
          prev <= rdata;
          k    <= k + AW'(1);
        end else begin
          c0   <= prev[COLOR_W-1:0];
          c1   <= rd_col;
          t    <= g - prev_pos;
          span <= rd_pos - prev_pos;
          ch   <= '0;
        end
      end
      S_L_WAIT: begin
        if (div_done) begin
          color[8*ch +: 8] <= div_quo[7:0];
          ch <= ch + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign result.pixel_color   = color;
  assign result.pixel_address = addr;

  lgps_div u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (div_go),
    .num    (div_num),
    .den    (div_den),
    .steps  (div_steps),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rnz)
  );

  lgps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_STOPS)
  ) u_stops (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_shade_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type == REQ_SHADE) |=> busy)
    else $error("shade item did not start work");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && request.req_type == REQ_LOAD) |=> !busy)
    else $error("load item left the block busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without an item in flight");

endmodule
